>>> hdl/npm_pkg.sv
// npm_pkg: shared types and constants for the nearest point matcher.
// No dependencies; used by every other file under hdl.
package npm_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 16;
	localparam int PORT_COORD_W   = 16;
	localparam int INDEX_W        = 10;
	localparam int DIST_W         = 34;
	localparam int CMDQ_DEPTH     = 4;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_LOADED  = 3'd0,
		ST_DROPPED = 3'd1,
		ST_MATCH   = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	// decoded command as held in the front queue; coordinates as raw port bits
	typedef struct packed {
		op_t                     op;
		logic [PORT_COORD_W-1:0] x;
		logic [PORT_COORD_W-1:0] y;
		logic [PORT_COORD_W-1:0] z;
	} cmd_t;

endpackage

>>> hdl/npm_front.sv
// npm_front: input side of the matcher; decodes op, drops the unused code
// and holds accepted commands in a short queue. Depends on npm_pkg.
module npm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [1:0]                          op,
	input  logic signed [npm_pkg::PORT_COORD_W-1:0] px,
	input  logic signed [npm_pkg::PORT_COORD_W-1:0] py,
	input  logic signed [npm_pkg::PORT_COORD_W-1:0] pz,
	output npm_pkg::cmd_t                       cmd,
	output logic                                cmd_valid,
	input  logic                                cmd_take
);

	localparam int DEPTH = npm_pkg::CMDQ_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	npm_pkg::cmd_t  fifo_q [DEPTH];
	npm_pkg::cmd_t  new_cmd;
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    cnt_q;
	logic           keep;
	logic           wr_en;
	logic           rd_en;

	// op 3 is a valid transfer but carries no work
	always_comb begin
		unique case (op)
			npm_pkg::OP_LOAD, npm_pkg::OP_QUERY, npm_pkg::OP_CLEAR: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign new_cmd.op = npm_pkg::op_t'(op);
	assign new_cmd.x  = px;
	assign new_cmd.y  = py;
	assign new_cmd.z  = pz;

	assign full      = (cnt_q == (PW+1)'(DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign wr_en     = push && !full && keep;
	assign rd_en     = cmd_take && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + (PW+1)'(1);
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			fifo_q[wr_ptr_q] <= new_cmd;
	end

endmodule

>>> hdl/npm_back.sv
// npm_back: executes commands: point store, scan pipeline, best-match
// tracking and the result register. Depends on npm_pkg.
module npm_back #(
	parameter int MAX_POINTS = npm_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = npm_pkg::COORD_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  npm_pkg::cmd_t                           cmd,
	input  logic                                    cmd_valid,
	output logic                                    cmd_take,
	output logic                                    res_valid,
	input  logic                                    res_pop,
	output npm_pkg::status_t                        status,
	output logic [npm_pkg::INDEX_W-1:0]             match_index,
	output logic signed [npm_pkg::PORT_COORD_W-1:0] match_x,
	output logic signed [npm_pkg::PORT_COORD_W-1:0] match_y,
	output logic signed [npm_pkg::PORT_COORD_W-1:0] match_z,
	output logic [npm_pkg::DIST_W-1:0]              dist_sq
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int CB = COORD_BITS;
	localparam int SW = 2*CB + 1;
	localparam int DW = 2*CB + 2;

	typedef logic signed [CB-1:0] crd_t;
	typedef struct packed {
		crd_t x;
		crd_t y;
		crd_t z;
	} pt_t;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN} state_t;

	pt_t               store [MAX_POINTS];
	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     addr_q;
	pt_t               qry_q;
	pt_t               cmd_pt;

	logic              v_s1, v_s2, v_s3;
	pt_t               pt_s1, pt_s2, pt_s3;
	logic [IW-1:0]     idx_s1, idx_s2, idx_s3;
	logic [SW-1:0]     sqx_s2, sqy_s2, sqz_s2;
	logic [DW-1:0]     dist_s3;

	logic [DW-1:0]     best_d_q;
	logic [IW-1:0]     best_idx_q;
	pt_t               best_pt_q;

	logic signed [CB:0]     dx, dy, dz;
	logic signed [2*CB+1:0] px2, py2, pz2;

	logic              out_free;
	logic              store_full;
	logic              issue;
	logic              last;
	logic              pipe_busy;
	logic              res_set;

	assign cmd_pt.x = crd_t'(CB'(cmd.x));
	assign cmd_pt.y = crd_t'(CB'(cmd.y));
	assign cmd_pt.z = crd_t'(CB'(cmd.z));

	assign out_free   = !res_valid || res_pop;
	assign cmd_take   = (state_q == S_IDLE) && cmd_valid && out_free;
	assign store_full = (count_q == CW'(MAX_POINTS));
	assign issue      = (state_q == S_SCAN);
	assign last       = (CW'(addr_q) == count_q - CW'(1));
	assign pipe_busy  = v_s1 || v_s2 || v_s3;
	// a result is written straight from a command, or at the end of a sweep
	assign res_set    = (cmd_take && ((cmd.op != npm_pkg::OP_QUERY) || (count_q == '0)))
		|| ((state_q == S_DRAIN) && !pipe_busy && out_free);

	// control, state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			addr_q      <= '0;
			qry_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid   <= 1'b0;
			status      <= npm_pkg::ST_LOADED;
			match_index <= '0;
			match_x     <= '0;
			match_y     <= '0;
			match_z     <= '0;
			dist_sq     <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (res_set)
				res_valid <= 1'b1;
			else if (res_pop)
				res_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						match_index <= '0;
						match_x     <= '0;
						match_y     <= '0;
						match_z     <= '0;
						dist_sq     <= '0;
						unique case (cmd.op)
							npm_pkg::OP_LOAD: begin
								if (store_full) begin
									status <= npm_pkg::ST_DROPPED;
								end else begin
									status  <= npm_pkg::ST_LOADED;
									count_q <= count_q + CW'(1);
								end
							end
							npm_pkg::OP_CLEAR: begin
								status    <= npm_pkg::ST_CLEARED;
								count_q   <= '0;
							end
							npm_pkg::OP_QUERY: begin
								if (count_q == '0) begin
									status    <= npm_pkg::ST_EMPTY;
								end else begin
									addr_q  <= '0;
									qry_q   <= cmd_pt;
									state_q <= S_SCAN;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					addr_q <= addr_q + IW'(1);
					if (last)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (!pipe_busy && out_free) begin
						status      <= npm_pkg::ST_MATCH;
						match_index <= npm_pkg::INDEX_W'(best_idx_q);
						match_x     <= npm_pkg::PORT_COORD_W'(best_pt_q.x);
						match_y     <= npm_pkg::PORT_COORD_W'(best_pt_q.y);
						match_z     <= npm_pkg::PORT_COORD_W'(best_pt_q.z);
						dist_sq     <= npm_pkg::DIST_W'(best_d_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// point store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd_take && (cmd.op == npm_pkg::OP_LOAD) && !store_full)
			store[count_q[IW-1:0]] <= cmd_pt;
		if (issue) begin
			pt_s1  <= store[addr_q];
			idx_s1 <= addr_q;
		end
	end

	always_comb begin
		dx  = {pt_s1.x[CB-1], pt_s1.x} - {qry_q.x[CB-1], qry_q.x};
		dy  = {pt_s1.y[CB-1], pt_s1.y} - {qry_q.y[CB-1], qry_q.y};
		dz  = {pt_s1.z[CB-1], pt_s1.z} - {qry_q.z[CB-1], qry_q.z};
		px2 = dx * dx;
		py2 = dy * dy;
		pz2 = dz * dz;
	end

	// s2: squares, s3: sum, then running minimum
	always_ff @(posedge clk) begin
		sqx_s2  <= px2[SW-1:0];
		sqy_s2  <= py2[SW-1:0];
		sqz_s2  <= pz2[SW-1:0];
		pt_s2   <= pt_s1;
		idx_s2  <= idx_s1;
		dist_s3 <= DW'(sqx_s2) + DW'(sqy_s2) + DW'(sqz_s2);
		pt_s3   <= pt_s2;
		idx_s3  <= idx_s2;
		// strict less-than keeps the lowest index on a tie
		if (v_s3 && ((idx_s3 == '0) || (dist_s3 < best_d_q))) begin
			best_d_q   <= dist_s3;
			best_idx_q <= idx_s3;
			best_pt_q  <= pt_s3;
		end
	end

endmodule

>>> hdl/nearest_point_matcher.sv
// nearest_point_matcher: top level of the brute-force 3D closest-point search.
// Depends on npm_pkg, npm_front and npm_back.
//
// Channel   Direction  Transfer when       Fields
// --------  ---------  ------------------  ----------------------------------------------
// command   in         push && !full       op, px, py, pz
// result    out        pop && !empty       status, match_index, match_x/y/z, dist_sq
//
// With the back end idle, a load or clear result passes through the command
// queue and then the result register; a query result waits on the single
// read port of the point store, swept one entry per cycle, and on the
// three-stage distance pipeline behind it.
// Reset (arst_n low) empties the store count, the command queue and the
// result register; the point memory itself is not cleared.
// The four-entry command queue keeps accepting while a result waits; the
// back end stalls while a query sweeps the store or while the result
// register is still occupied.
module nearest_point_matcher #(
	parameter int MAX_POINTS = npm_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = npm_pkg::COORD_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  logic [1:0]                              op,
	input  logic signed [npm_pkg::PORT_COORD_W-1:0] px,
	input  logic signed [npm_pkg::PORT_COORD_W-1:0] py,
	input  logic signed [npm_pkg::PORT_COORD_W-1:0] pz,
	output logic                                    empty,
	input  logic                                    pop,
	output logic [2:0]                              status,
	output logic [npm_pkg::INDEX_W-1:0]             match_index,
	output logic signed [npm_pkg::PORT_COORD_W-1:0] match_x,
	output logic signed [npm_pkg::PORT_COORD_W-1:0] match_y,
	output logic signed [npm_pkg::PORT_COORD_W-1:0] match_z,
	output logic [npm_pkg::DIST_W-1:0]              dist_sq
);

	npm_pkg::cmd_t    cmd;
	logic             cmd_valid;
	logic             cmd_take;
	logic             res_valid;
	npm_pkg::status_t res_status;

	// front: decode and queue
	npm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.op        (op),
		.px        (px),
		.py        (py),
		.pz        (pz),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take)
	);

	// back: store, scan and result register
	npm_back #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cmd_valid   (cmd_valid),
		.cmd_take    (cmd_take),
		.res_valid   (res_valid),
		.res_pop     (pop),
		.status      (res_status),
		.match_index (match_index),
		.match_x     (match_x),
		.match_y     (match_y),
		.match_z     (match_z),
		.dist_sq     (dist_sq)
	);

	assign empty  = !res_valid;
	assign status = res_status;

endmodule

>>> hdl/npm_checker.sv
// npm_checker: port-level assertions for nearest_point_matcher, bound to
// the top level below. Depends on npm_pkg.
module npm_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    empty,
	input logic                                    pop,
	input logic [2:0]                              status,
	input logic [npm_pkg::INDEX_W-1:0]             match_index,
	input logic signed [npm_pkg::PORT_COORD_W-1:0] match_x,
	input logic signed [npm_pkg::PORT_COORD_W-1:0] match_y,
	input logic signed [npm_pkg::PORT_COORD_W-1:0] match_z,
	input logic [npm_pkg::DIST_W-1:0]              dist_sq
);

	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(status) && $stable(match_index)
			&& $stable(dist_sq))
		else $error("result changed while waiting");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> status <= npm_pkg::ST_CLEARED)
		else $error("status code out of range");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != npm_pkg::ST_MATCH |-> match_index == '0
			&& match_x == '0 && match_y == '0 && match_z == '0 && dist_sq == '0)
		else $error("non-match result carries match data");

	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> empty)
		else $error("result present straight after reset");

endmodule

bind nearest_point_matcher npm_checker u_npm_checker (.*);

>>> test/tb_nearest_point_matcher.sv
// tb_nearest_point_matcher: self-checking bench for the brute-force 3D closest-point search.
// Needs npm_pkg and nearest_point_matcher from hdl; runs a directed part and random
// load/query sessions against a predictor of its own.
module tb_nearest_point_matcher;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 11;
	localparam int STORE_DEPTH     = npm_pkg::MAX_POINTS_DEF;
	localparam int RANDOM_ITEMS    = 560;
	localparam int CW              = npm_pkg::PORT_COORD_W;
	// watchdog limit, well above the worst case; a run that reaches it counts as hung
	localparam int WATCHDOG_CYCLES = 2_000_000;
	// a query on a full store sweeps every entry, plus pipeline slack
	localparam int DRAIN_CYCLES    = STORE_DEPTH + 64;
	localparam int MAX_PRINTED     = 100;

	// op 3 is not decoded by the block; the package has no member for it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} point_t;

	typedef struct packed {
		logic [1:0] op;
		point_t     pt;
	} command_t;

	typedef struct packed {
		npm_pkg::status_t              status;
		logic [npm_pkg::INDEX_W-1:0]   index;
		logic signed [CW-1:0]          x;
		logic signed [CW-1:0]          y;
		logic signed [CW-1:0]          z;
		logic [npm_pkg::DIST_W-1:0]    dist_val;
	} answer_t;

	logic                                    clk    = 1'b0;
	logic                                    arst_n = 1'b0;
	logic                                    push   = 1'b0;
	logic                                    full;
	logic [1:0]                              op     = npm_pkg::OP_LOAD;
	logic signed [CW-1:0]                    px     = '0;
	logic signed [CW-1:0]                    py     = '0;
	logic signed [CW-1:0]                    pz     = '0;
	logic                                    empty;
	logic                                    pop    = 1'b0;
	logic [2:0]                              status;
	logic [npm_pkg::INDEX_W-1:0]             match_index;
	logic signed [CW-1:0]                    match_x;
	logic signed [CW-1:0]                    match_y;
	logic signed [CW-1:0]                    match_z;
	logic [npm_pkg::DIST_W-1:0]              dist_sq;

	nearest_point_matcher uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.px          (px),
		.py          (py),
		.pz          (pz),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.match_index (match_index),
		.match_x     (match_x),
		.match_y     (match_y),
		.match_z     (match_z),
		.dist_sq     (dist_sq)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow of the block: point store, count and the answers still owed
	// ------------------------------------------------------------------
	logic signed [CW-1:0] shadow_x [STORE_DEPTH];
	logic signed [CW-1:0] shadow_y [STORE_DEPTH];
	logic signed [CW-1:0] shadow_z [STORE_DEPTH];
	int unsigned          shadow_count = 0;

	answer_t  owed_answers [$];
	command_t cmd_backlog  [$];
	int       fault_count = 0;

	task automatic flag_fault(input string msg);
		if (fault_count < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
		fault_count++;
	endtask

	// squared distance, exact: three 17-bit differences squared fit easily in 64 bits
	function automatic longint unsigned sq_distance(input point_t a, input point_t b);
		longint dx;
		longint dy;
		longint dz;
		dx = longint'(a.x) - longint'(b.x);
		dy = longint'(a.y) - longint'(b.y);
		dz = longint'(a.z) - longint'(b.z);
		return longint'(dx * dx + dy * dy + dz * dz);
	endfunction

	// Applies one accepted transfer to the shadow and queues the answer it owes.
	task automatic match_command(input command_t c);
		answer_t         ans;
		point_t          cand;
		longint unsigned d;
		longint unsigned best_d;
		int unsigned     best;
		ans    = '0;
		best   = 0;
		best_d = 0;
		case (c.op)
			npm_pkg::OP_LOAD: begin
				if (shadow_count >= STORE_DEPTH) begin
					ans.status = npm_pkg::ST_DROPPED;
				end else begin
					shadow_x[shadow_count] = c.pt.x;
					shadow_y[shadow_count] = c.pt.y;
					shadow_z[shadow_count] = c.pt.z;
					shadow_count++;
					ans.status = npm_pkg::ST_LOADED;
				end
			end
			npm_pkg::OP_QUERY: begin
				if (shadow_count == 0) begin
					ans.status = npm_pkg::ST_EMPTY;
				end else begin
					for (int unsigned i = 0; i < shadow_count; i++) begin
						cand = '{shadow_x[i], shadow_y[i], shadow_z[i]};
						d = sq_distance(cand, c.pt);
						// strict less-than: the lowest index keeps a tie
						if (i == 0 || d < best_d) begin
							best_d = d;
							best   = i;
						end
					end
					ans.status   = npm_pkg::ST_MATCH;
					ans.index    = best[npm_pkg::INDEX_W-1:0];
					ans.x        = shadow_x[best];
					ans.y        = shadow_y[best];
					ans.z        = shadow_z[best];
					ans.dist_val = best_d[npm_pkg::DIST_W-1:0];
				end
			end
			npm_pkg::OP_CLEAR: begin
				shadow_count = 0;
				ans.status   = npm_pkg::ST_CLEARED;
			end
			default: return; // unused opcode: nothing changes, nothing comes back
		endcase
		owed_answers.push_back(ans);
	endtask

	// ------------------------------------------------------------------
	// Monitor: input transfers feed the predictor, result transfers are checked
	// ------------------------------------------------------------------
	logic    took = 1'b0; // the command on the ports transferred at the last rising edge
	answer_t want;

	always @(posedge clk) begin
		took <= arst_n && push && !full;
		if (arst_n && push && !full)
			match_command('{op, '{px, py, pz}});
		if (arst_n && pop && !empty) begin
			if (owed_answers.size() == 0) begin
				flag_fault($sformatf("result transfer with nothing outstanding, status %0d",
					status));
			end else begin
				want = owed_answers.pop_front();
				if (status !== want.status)
					flag_fault($sformatf("status got %0d want %0d", status, want.status));
				if (match_index !== want.index)
					flag_fault($sformatf("match_index got %0d want %0d",
						match_index, want.index));
				if (match_x !== want.x)
					flag_fault($sformatf("match_x got %0d want %0d", match_x, want.x));
				if (match_y !== want.y)
					flag_fault($sformatf("match_y got %0d want %0d", match_y, want.y));
				if (match_z !== want.z)
					flag_fault($sformatf("match_z got %0d want %0d", match_z, want.z));
				if (dist_sq !== want.dist_val)
					flag_fault($sformatf("dist_sq got %0d want %0d", dist_sq,
						want.dist_val));
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver: bursts of random length, random gaps in between
	// ------------------------------------------------------------------
	int       burst_left = 1;
	int       gap_left   = 0;
	command_t drive_cmd;

	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || took) begin
			if (gap_left > 0 || cmd_backlog.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				push <= 1'b0;
			end else begin
				drive_cmd = cmd_backlog.pop_front();
				op   <= drive_cmd.op;
				px   <= drive_cmd.pt.x;
				py   <= drive_cmd.pt.y;
				pz   <= drive_cmd.pt.z;
				push <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					// a quarter of bursts run straight into the next one
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: own stall pattern, with calm stretches of steady popping
	// ------------------------------------------------------------------
	int stall_left = 0;
	int calm_left  = 0;
	int stall_roll;

	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			stall_roll = $urandom_range(0, 99);
			if (calm_left > 0)
				calm_left--;
			else if (stall_roll < 10)
				stall_left = $urandom_range(2, 20);
			else if (stall_roll < 40)
				stall_left = 1;
			else if (stall_roll >= 97)
				calm_left = $urandom_range(50, 200);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	point_t loaded_pts [$]; // what the store will hold at this point of the sequence

	function automatic logic signed [CW-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			2:       return 16'($urandom_range(0, 1) ? 0 : -1);
			3, 4:    return 16'($urandom_range(0, 64)) - 16'sd32;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic point_t pick_point();
		return '{pick_coord(), pick_coord(), pick_coord()};
	endfunction

	task automatic add_cmd(input logic [1:0] o, input point_t p);
		cmd_backlog.push_back('{o, p});
		if (o == npm_pkg::OP_LOAD)
			loaded_pts.push_back(p);
		else if (o == npm_pkg::OP_CLEAR)
			loaded_pts.delete();
	endtask

	// a query point: often a stored point or a near neighbour, so ties and dist 0 appear
	function automatic point_t pick_query();
		point_t q;
		int     roll;
		roll = $urandom_range(0, 9);
		if (loaded_pts.size() == 0 || roll >= 6)
			return pick_point();
		q = loaded_pts[$urandom_range(0, loaded_pts.size() - 1)];
		if (roll >= 3) begin
			q.x = q.x + 16'($urandom_range(0, 6)) - 16'sd3;
			q.y = q.y + 16'($urandom_range(0, 6)) - 16'sd3;
			q.z = q.z + 16'($urandom_range(0, 6)) - 16'sd3;
		end
		return q;
	endfunction

	int     counted;
	int     n_loads;
	int     n_queries;
	point_t p;

	initial begin
		// directed: empty store, extremes, ties, unused opcode
		add_cmd(npm_pkg::OP_QUERY, '{16'sd0, 16'sd0, 16'sd0});
		add_cmd(npm_pkg::OP_CLEAR, '{16'sd0, 16'sd0, 16'sd0});
		add_cmd(npm_pkg::OP_LOAD,  '{16'sh8000, 16'sh8000, 16'sh8000});
		add_cmd(npm_pkg::OP_QUERY, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}); // largest distance
		add_cmd(npm_pkg::OP_LOAD,  '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
		add_cmd(npm_pkg::OP_LOAD,  '{16'sd0, 16'sd0, 16'sd0});
		add_cmd(npm_pkg::OP_LOAD,  '{16'sd0, 16'sd0, 16'sd0});          // duplicate for a tie
		add_cmd(npm_pkg::OP_QUERY, '{16'sd0, 16'sd0, 16'sd0});
		add_cmd(npm_pkg::OP_QUERY, '{16'sd1, -16'sd1, 16'sd0});
		add_cmd(OP_UNUSED, '{-16'sd1, -16'sd1, -16'sd1});
		add_cmd(npm_pkg::OP_QUERY, '{16'sh7FFF, 16'sh8000, 16'sd0});
		add_cmd(npm_pkg::OP_LOAD,  '{-16'sd1, -16'sd1, -16'sd1});
		add_cmd(npm_pkg::OP_QUERY, '{-16'sd1, 16'sd0, -16'sd1});
		add_cmd(npm_pkg::OP_QUERY, '{16'sh8001, 16'sh8000, 16'sh8000});
		add_cmd(npm_pkg::OP_CLEAR, '{-16'sd1, -16'sd1, -16'sd1});
		add_cmd(npm_pkg::OP_QUERY, '{16'sd5, 16'sd5, 16'sd5});
		add_cmd(npm_pkg::OP_LOAD,  '{16'sd5, -16'sd5, 16'sd5});
		add_cmd(npm_pkg::OP_QUERY, '{16'sd5, -16'sd5, 16'sd5});

		// random sessions: mostly clear, load a handful, query; some noise mixed in
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if (loaded_pts.size() > 300 || $urandom_range(0, 4) != 0) begin
				add_cmd(npm_pkg::OP_CLEAR, pick_point());
				counted++;
			end
			n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
				: $urandom_range(0, 24);
			for (int i = 0; i < n_loads; i++) begin
				if (loaded_pts.size() > 0 && $urandom_range(0, 5) == 0)
					p = loaded_pts[$urandom_range(0, loaded_pts.size() - 1)];
				else
					p = pick_point();
				add_cmd(npm_pkg::OP_LOAD, p);
				counted++;
			end
			n_queries = $urandom_range(1, 12);
			for (int i = 0; i < n_queries; i++) begin
				case ($urandom_range(0, 19))
					0:       add_cmd(OP_UNUSED, pick_point());
					1:       begin add_cmd(npm_pkg::OP_LOAD, pick_point()); counted++; end
					default: begin add_cmd(npm_pkg::OP_QUERY, pick_query()); counted++; end
				endcase
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every command taken, every answer in, then let any late result show itself
		while (cmd_backlog.size() != 0 || push)
			@(posedge clk);
		while (owed_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0 && owed_answers.size() == 0)
			$display("[nearest_point_matcher] OK");
		else
			$display("[nearest_point_matcher] ERROR");
		$finish;
	end

	// watchdog for a hung handshake
	initial begin
		#(WATCHDOG_CYCLES * CLK_PERIOD);
		$display("[nearest_point_matcher] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
hdl/npm_pkg.sv
hdl/npm_front.sv
hdl/npm_back.sv
hdl/nearest_point_matcher.sv
hdl/npm_checker.sv
test/tb_nearest_point_matcher.sv
